// File: design/mi_pkg.sv
`default_nettype none
package mi_pkg;

   typedef struct packed {
      logic load;
      logic setup;
      logic align;
      logic sub;
      logic set_r1;
      logic update;
      logic finish;
   } mi_cmd_type;

   typedef struct packed {
      logic m_zero;
      logic can_align;
      logic k_zero;
      logic r1_zero;
      logic step_limit;
   } mi_status_type;

endpackage
`default_nettype wire

// File: design/mi_ctrl.sv
`default_nettype none
module mi_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire mi_pkg::mi_status_type status,
   output      mi_pkg::mi_cmd_type    cmd,
   output      logic                  busy,
   output      logic                  done
);
   import mi_pkg::*;

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StRAlign = 3'd1;
   localparam logic [2:0] StRSub   = 3'd2;
   localparam logic [2:0] StRSet   = 3'd3;
   localparam logic [2:0] StLoop   = 3'd4;
   localparam logic [2:0] StAlign  = 3'd5;
   localparam logic [2:0] StSub    = 3'd6;
   localparam logic [2:0] StFinish = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       done_ff, done_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         StIdle: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = StRAlign;
            end
         end
         StRAlign: begin
            priority if (status.m_zero) begin
               state_in = StFinish;
            end else if (status.can_align) begin
               cmd.align = 1'b1;
            end else begin
               state_in = StRSub;
            end
         end
         StRSub: begin
            cmd.sub = 1'b1;
            if (status.k_zero) state_in = StRSet;
         end
         StRSet: begin
            cmd.set_r1 = 1'b1;
            state_in   = StLoop;
         end
         StLoop: begin
            if (status.r1_zero || status.step_limit) begin
               state_in = StFinish;
            end else begin
               cmd.setup = 1'b1;
               state_in  = StAlign;
            end
         end
         StAlign: begin
            if (status.can_align) cmd.align = 1'b1;
            else state_in = StSub;
         end
         StSub: begin
            cmd.sub = 1'b1;
            if (status.k_zero) begin
               cmd.update = 1'b1;
               state_in   = StLoop;
            end
         end
         StFinish: begin
            cmd.finish = 1'b1;
            state_in   = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   assign done_in = (state_ff == StFinish);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign busy = (state_ff != StIdle);
   assign done = done_ff;
endmodule
`default_nettype wire

// File: design/mi_dp.sv
`default_nettype none
module mi_dp #(
   parameter int WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire mi_pkg::mi_cmd_type    cmd,
   input  wire logic [WIDTH-1:0]      operand,
   input  wire logic [WIDTH-1:0]      modulus,
   output      mi_pkg::mi_status_type status,
   output      logic [WIDTH-1:0]      inverse,
   output      logic                  no_inverse
);
   import mi_pkg::*;

   localparam int KW = $clog2(WIDTH + 1);
   localparam int SW = $clog2(2 * WIDTH + 3);
   localparam logic [SW-1:0] StepLimit = SW'(2 * WIDTH + 2);

   logic [WIDTH-1:0] m_ff, m_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [WIDTH-1:0] u0_ff, u0_in, u1_ff, u1_in;
   logic             neg0_ff, neg0_in, neg1_ff, neg1_in;
   logic [WIDTH-1:0] rem_ff, rem_in, acc_ff, acc_in;
   logic [WIDTH:0]   d_ff, d_in, e_ff, e_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [WIDTH-1:0] inverse_ff, inverse_in;
   logic             none_ff, none_in;

   logic             ge;
   logic [WIDTH-1:0] diff;
   logic [WIDTH-1:0] u0_red, inv_val;

   assign ge      = (d_ff <= {1'b0, rem_ff});
   assign diff    = rem_ff - d_ff[WIDTH-1:0];
   assign u0_red  = (u0_ff == m_ff) ? '0 : u0_ff;
   assign inv_val = (neg0_ff && (u0_red != '0)) ? (m_ff - u0_red) : u0_red;

   always_comb begin
      m_in       = m_ff;
      r0_in      = r0_ff;
      r1_in      = r1_ff;
      u0_in      = u0_ff;
      u1_in      = u1_ff;
      neg0_in    = neg0_ff;
      neg1_in    = neg1_ff;
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      d_in       = d_ff;
      e_in       = e_ff;
      k_in       = k_ff;
      step_in    = step_ff;
      inverse_in = inverse_ff;
      none_in    = none_ff;
      if (cmd.load) begin
         m_in    = modulus;
         r0_in   = modulus;
         u0_in   = '0;
         u1_in   = WIDTH'(1);
         neg0_in = 1'b0;
         neg1_in = 1'b0;
         rem_in  = operand;
         acc_in  = '0;
         d_in    = {1'b0, modulus};
         e_in    = '0;
         k_in    = '0;
         step_in = '0;
      end
      if (cmd.setup) begin
         rem_in = r0_ff;
         acc_in = u0_ff;
         d_in   = {1'b0, r1_ff};
         e_in   = {1'b0, u1_ff};
         k_in   = '0;
      end
      if (cmd.align) begin
         d_in = {d_ff[WIDTH-1:0], 1'b0};
         e_in = {e_ff[WIDTH-1:0], 1'b0};
         k_in = k_ff + KW'(1);
      end
      if (cmd.sub) begin
         if (ge) begin
            rem_in = diff;
            acc_in = acc_ff + e_ff[WIDTH-1:0];
         end
         if (k_ff != '0) begin
            d_in = d_ff >> 1;
            e_in = e_ff >> 1;
            k_in = k_ff - KW'(1);
         end
      end
      if (cmd.set_r1) begin
         r1_in = rem_ff;
      end
      if (cmd.update) begin
         r0_in   = r1_ff;
         r1_in   = ge ? diff : rem_ff;
         u0_in   = u1_ff;
         u1_in   = ge ? (acc_ff + e_ff[WIDTH-1:0]) : acc_ff;
         neg0_in = neg1_ff;
         neg1_in = ~neg1_ff;
         step_in = step_ff + SW'(1);
      end
      if (cmd.finish) begin
         if (r0_ff == WIDTH'(1)) begin
            inverse_in = inv_val;
            none_in    = 1'b0;
         end else begin
            inverse_in = '0;
            none_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff       <= m_in;
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      u0_ff      <= u0_in;
      u1_ff      <= u1_in;
      neg0_ff    <= neg0_in;
      neg1_ff    <= neg1_in;
      rem_ff     <= rem_in;
      acc_ff     <= acc_in;
      d_ff       <= d_in;
      e_ff       <= e_in;
      k_ff       <= k_in;
      step_ff    <= step_in;
      inverse_ff <= inverse_in;
      none_ff    <= none_in;
   end

   assign status.m_zero     = (m_ff == '0);
   assign status.can_align  = ({d_ff, 1'b0} <= {2'b00, rem_ff});
   assign status.k_zero     = (k_ff == '0);
   assign status.r1_zero    = (r1_ff == '0);
   assign status.step_limit = (step_ff == StepLimit);

   assign inverse    = inverse_ff;
   assign no_inverse = none_ff;
endmodule
`default_nettype wire

// File: design/modular_inverse_core.sv
// channel   handshake                 payload
// request   start & !busy             req_operand, req_modulus
// response  rsp_valid (one cycle)     rsp_inverse, rsp_no_inverse
//
// One transaction at a time; busy stays high from acceptance until the result.
// Each transaction loads, reduces the operand modulo the modulus, then runs Euclid steps;
// each quotient comes from the shift-subtract divider (align, then subtract). rsp_valid
// pulses the cycle busy falls; start may be taken in that same cycle. Synchronous reset
// returns to idle; no stalls.
`default_nettype none
module modular_inverse_core #(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire logic [WIDTH-1:0] req_operand,
   input  wire logic [WIDTH-1:0] req_modulus,
   output      logic             rsp_valid,
   output      logic [WIDTH-1:0] rsp_inverse,
   output      logic             rsp_no_inverse
);
   import mi_pkg::*;

   mi_cmd_type    cmd;
   mi_status_type status;

   mi_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_valid)
   );

   mi_dp #(.WIDTH(WIDTH)) u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .operand    (req_operand),
      .modulus    (req_modulus),
      .status     (status),
      .inverse    (rsp_inverse),
      .no_inverse (rsp_no_inverse)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside end of transaction");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_inverse) |-> (rsp_inverse == '0))
      else $error("nonzero inverse with no-inverse flag");
endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDTH = 32;
   localparam int RANDOM_ITEMS = 1925;
   localparam int DRAIN_LIMIT = 5000;
   localparam int TAIL_CYCLES = 400;

   typedef struct packed {
      logic [WIDTH-1:0] inverse;
      logic             no_inverse;
   } inverse_result_type;

   class inverse_scoreboard;
      inverse_result_type expected_inverses[$];
      int                 failures;

      function new();
         failures = 0;
      endfunction

      function inverse_result_type predict_inverse(logic [WIDTH-1:0] operand,
                                                   logic [WIDTH-1:0] modulus);
         logic [63:0]        r0, r1, u0, u1, q, tr, tu;
         logic               neg0, neg1;
         inverse_result_type res;
         res.inverse = '0;
         res.no_inverse = 1'b1;
         if (modulus != 0) begin
            r0 = 64'(modulus);
            r1 = 64'(operand) % 64'(modulus);
            u0 = 64'd0;
            u1 = 64'd1;
            neg0 = 1'b0;
            neg1 = 1'b0;
            for (int step = 0; step < 2 * WIDTH + 2 && r1 != 0; step++) begin
               q = r0 / r1;
               tr = r0 - q * r1;
               r0 = r1;
               r1 = tr;
               tu = u0 + q * u1;
               u0 = u1;
               u1 = tu;
               neg0 = neg1;
               neg1 = ~neg1;
            end
            if (r0 == 64'd1) begin
               u0 = u0 % 64'(modulus);
               res.inverse = (neg0 && u0 != 0) ? WIDTH'(64'(modulus) - u0) : WIDTH'(u0);
               res.no_inverse = 1'b0;
            end
         end
         return res;
      endfunction

      function void note_request(logic [WIDTH-1:0] operand, logic [WIDTH-1:0] modulus);
         expected_inverses.push_back(predict_inverse(operand, modulus));
      endfunction

      function void check_response(logic [WIDTH-1:0] inverse, logic no_inverse);
         inverse_result_type want;
         if (expected_inverses.size() == 0) begin
            $display("%0t: unexpected response inverse=%h no_inverse=%b",
                     $time, inverse, no_inverse);
            failures++;
            return;
         end
         want = expected_inverses.pop_front();
         if (want.inverse !== inverse) begin
            $display("%0t: inverse mismatch expected=%h actual=%h",
                     $time, want.inverse, inverse);
            failures++;
         end
         if (want.no_inverse !== no_inverse) begin
            $display("%0t: no_inverse mismatch expected=%b actual=%b",
                     $time, want.no_inverse, no_inverse);
            failures++;
         end
      endfunction

      function int pending();
         return expected_inverses.size();
      endfunction

      function void check_leftovers();
         if (expected_inverses.size() != 0) begin
            $display("%0t: %0d responses missing, expected inverse=%h no_inverse=%b",
                     $time, expected_inverses.size(), expected_inverses[0].inverse,
                     expected_inverses[0].no_inverse);
            failures++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [WIDTH-1:0] req_operand = '0;
   logic [WIDTH-1:0] req_modulus = '0;
   logic             rsp_valid;
   logic [WIDTH-1:0] rsp_inverse;
   logic             rsp_no_inverse;

   inverse_scoreboard sb = new();
   int                burst_left = 0;
   bit                drain_timeout = 1'b0;

   modular_inverse_core #(.WIDTH(WIDTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operand    (req_operand),
      .req_modulus    (req_modulus),
      .rsp_valid      (rsp_valid),
      .rsp_inverse    (rsp_inverse),
      .rsp_no_inverse (rsp_no_inverse)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_inverse, rsp_no_inverse);
   end

   task automatic send_item(input logic [WIDTH-1:0] operand, input logic [WIDTH-1:0] modulus);
      int gap;
      req_operand <= operand;
      req_modulus <= modulus;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(operand, modulus);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 8);
         if ($urandom_range(0, 99) == 0)
            burst_left = $urandom_range(20, 60);
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      int waited;
      waited = 0;
      start <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (sb.pending() != 0 && waited < DRAIN_LIMIT);
      if (sb.pending() != 0)
         drain_timeout = 1'b1;
   endtask

   task automatic send_random_item();
      logic [WIDTH-1:0] operand, modulus, g;
      int               kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: begin
            operand = $urandom;
            modulus = $urandom;
         end
         3: begin
            modulus = $urandom_range(1, 64);
            operand = $urandom;
         end
         4: begin
            modulus = $urandom >> $urandom_range(0, 31);
            operand = $urandom;
            if (modulus != 0)
               operand = operand % modulus;
         end
         5: begin
            g = $urandom_range(2, 1000);
            operand = g * $urandom_range(0, 4_000_000);
            modulus = g * $urandom_range(1, 4_000_000);
         end
         6: begin
            modulus = $urandom | 32'h1;
            operand = $urandom_range(0, 1) ? $urandom_range(0, 15) : ~$urandom_range(0, 15);
         end
         7: begin
            modulus = ~WIDTH'($urandom_range(0, 255));
            operand = $urandom;
         end
         default: begin
            modulus = $urandom | 32'h8000_0001;
            operand = $urandom;
         end
      endcase
      if (modulus == 0)
         modulus = 1;
      send_item(operand, modulus);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(32'h0, 32'h1);
      send_item(32'h5, 32'h1);
      send_item(32'hFFFF_FFFF, 32'h1);
      send_item(32'h0, 32'h7);
      send_item(32'h3, 32'h7);
      send_item(32'hA, 32'h7);
      send_item(32'hE, 32'h7);
      send_item(32'h6, 32'h9);
      send_item(32'h1, 32'h2);
      send_item(32'h0, 32'h2);
      send_item(32'h1, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_item(32'hFFFF_FFFF, 32'h2);
      send_item(32'd2971215073, 32'd1836311903);
      send_item(32'd1836311903, 32'd2971215073);
      send_item(32'h2, 32'd4294967291);
      send_item(32'h3, 32'h8000_0000);
      send_item(32'h1, 32'h8000_0000);
      send_item(32'h0000_3039, 32'h0000_3039);
      send_item(32'h7FFF_FFFF, 32'h8000_0000);
      send_item(32'hAAAA_AAAA, 32'h5555_5555);
      send_item(32'h5555_5555, 32'hAAAA_AAAB);
      drain_responses();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_random_item();
         if (i == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0)
            drain_responses();
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.check_leftovers();
      if (sb.failures == 0 && !drain_timeout)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
design/mi_pkg.sv
design/mi_ctrl.sv
design/mi_dp.sv
design/modular_inverse_core.sv
dv/tb_top.sv
